@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL of the CPU execute unit, used by its top-level file.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Whenever the condition holds, the consequence must hold in the same cycle.
`define ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/cpu8_exe_pkg.sv @@
// Package of the CPU execute unit: operation codes, flag positions and payload types.
// Used by cpu8_exe_alu, cpu8_register_alu_execute and the testbench; depends on nothing.
package cpu8_exe_pkg;

  // Operation codes.
  localparam logic [5:0] FUNC_LDA = 6'd0;
  localparam logic [5:0] FUNC_LDX = 6'd1;
  localparam logic [5:0] FUNC_LDY = 6'd2;
  localparam logic [5:0] FUNC_AND = 6'd3;
  localparam logic [5:0] FUNC_ORA = 6'd4;
  localparam logic [5:0] FUNC_EOR = 6'd5;
  localparam logic [5:0] FUNC_BIT = 6'd6;
  localparam logic [5:0] FUNC_ADC = 6'd7;
  localparam logic [5:0] FUNC_SBC = 6'd8;
  localparam logic [5:0] FUNC_CMP = 6'd9;
  localparam logic [5:0] FUNC_CPX = 6'd10;
  localparam logic [5:0] FUNC_CPY = 6'd11;
  localparam logic [5:0] FUNC_ASL = 6'd12;
  localparam logic [5:0] FUNC_LSR = 6'd13;
  localparam logic [5:0] FUNC_ROL = 6'd14;
  localparam logic [5:0] FUNC_ROR = 6'd15;
  localparam logic [5:0] FUNC_INC = 6'd16;
  localparam logic [5:0] FUNC_DEC = 6'd17;
  localparam logic [5:0] FUNC_INX = 6'd18;
  localparam logic [5:0] FUNC_INY = 6'd19;
  localparam logic [5:0] FUNC_DEX = 6'd20;
  localparam logic [5:0] FUNC_DEY = 6'd21;
  localparam logic [5:0] FUNC_TAX = 6'd22;
  localparam logic [5:0] FUNC_TAY = 6'd23;
  localparam logic [5:0] FUNC_TXA = 6'd24;
  localparam logic [5:0] FUNC_TYA = 6'd25;
  localparam logic [5:0] FUNC_CLC = 6'd26;
  localparam logic [5:0] FUNC_SEC = 6'd27;
  localparam logic [5:0] FUNC_CLD = 6'd28;
  localparam logic [5:0] FUNC_SED = 6'd29;
  localparam logic [5:0] FUNC_CLI = 6'd30;
  localparam logic [5:0] FUNC_SEI = 6'd31;
  localparam logic [5:0] FUNC_CLV = 6'd32;
  localparam logic [5:0] FUNC_STA = 6'd33;
  localparam logic [5:0] FUNC_STX = 6'd34;
  localparam logic [5:0] FUNC_STY = 6'd35;
  localparam logic [5:0] FUNC_PLP = 6'd36;
  localparam logic [5:0] FUNC_PHP = 6'd37;

  // Bit positions in the packed status byte.
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_B = 4;
  localparam int FLAG_U = 5;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  // Status after reset: only the unused bit is set.
  localparam logic [7:0] FLAGS_RESET = 8'h20;

  // One operation handed to the unit.
  typedef struct packed {
    logic [5:0] func;
    logic [7:0] operand;
    logic       on_accumulator;
  } op_t;

  // One result handed back by the unit.
  typedef struct packed {
    logic [7:0] result;
    logic       write_back;
    logic [7:0] status;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
  } rsp_t;

  // Programmer-visible registers.
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] flags;
  } arch_state_t;

endpackage

@@ hw/rtl/cpu8_exe_alu.sv @@
// Combinational datapath of the CPU execute unit: ALU, shifter and flag logic.
// Depends on cpu8_exe_pkg for operation codes, flag positions and types.
module cpu8_exe_alu (
  input  cpu8_exe_pkg::op_t         op,
  input  cpu8_exe_pkg::arch_state_t state,
  output cpu8_exe_pkg::arch_state_t state_next,
  output logic [7:0]                result,
  output logic                      write_back
);

  logic [7:0] a;
  logic [7:0] m;
  logic       c_in;

  // Binary and decimal adder and subtractor signals.
  logic [8:0] bin_sum;
  logic [8:0] bin_diff;
  logic [4:0] adc_lo;
  logic [9:0] adc_hi;
  logic [4:0] sbc_lo;
  logic [9:0] sbc_hi;
  logic [7:0] adc_r;
  logic       adc_c;
  logic [7:0] sbc_r;
  logic       sbc_c;

  // Compare and shift signals.
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  logic [7:0] shift_src;
  logic [7:0] shift_r;
  logic       shift_c;

  // Value that sets N and Z, and whether this operation updates them.
  logic [7:0] nz_val;
  logic       nz_en;

  assign a    = state.acc;
  assign m    = op.operand;
  assign c_in = state.flags[cpu8_exe_pkg::FLAG_C];

  // Add with carry, in binary and in decimal.
  always_comb begin
    bin_sum = {1'b0, a} + {1'b0, m} + {8'b0, c_in};
    adc_lo  = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'b0, c_in};
    adc_hi  = {2'b0, a[7:4], 4'b0} + {2'b0, m[7:4], 4'b0};
    if (adc_lo > 5'd9) begin
      adc_hi = adc_hi + 10'h010;
      adc_lo = adc_lo + 5'd6;
    end
    if (adc_hi > 10'h090) begin
      adc_hi = adc_hi + 10'h060;
    end
    if (state.flags[cpu8_exe_pkg::FLAG_D]) begin
      adc_r = {adc_hi[7:4], adc_lo[3:0]};
      adc_c = |adc_hi[9:8];
    end else begin
      adc_r = bin_sum[7:0];
      adc_c = bin_sum[8];
    end
  end

  // Subtract with borrow, in binary and in decimal. A clear carry means borrow.
  always_comb begin
    bin_diff = {1'b0, a} - {1'b0, m} - {8'b0, ~c_in};
    sbc_lo   = {1'b0, a[3:0]} - {1'b0, m[3:0]} - {4'b0, ~c_in};
    sbc_hi   = {2'b0, a[7:4], 4'b0} - {2'b0, m[7:4], 4'b0};
    if (sbc_lo[4]) begin
      sbc_hi = sbc_hi - 10'h010;
      sbc_lo = sbc_lo - 5'd6;
    end
    if (sbc_hi[8]) begin
      sbc_hi = sbc_hi - 10'h060;
    end
    if (state.flags[cpu8_exe_pkg::FLAG_D]) begin
      sbc_r = {sbc_hi[7:4], sbc_lo[3:0]};
      sbc_c = ~sbc_hi[9];
    end else begin
      sbc_r = bin_diff[7:0];
      sbc_c = ~bin_diff[8];
    end
  end

  // Register compares share one subtractor.
  always_comb begin
    case (op.func)
      cpu8_exe_pkg::FUNC_CPX: cmp_reg = state.x;
      cpu8_exe_pkg::FUNC_CPY: cmp_reg = state.y;
      default:                cmp_reg = state.acc;
    endcase
    cmp_diff = {1'b0, cmp_reg} - {1'b0, m};
  end

  // Shifts and rotates on the accumulator or on the memory byte.
  always_comb begin
    shift_src = op.on_accumulator ? state.acc : m;
    case (op.func)
      cpu8_exe_pkg::FUNC_ASL: begin
        shift_r = {shift_src[6:0], 1'b0};
        shift_c = shift_src[7];
      end
      cpu8_exe_pkg::FUNC_LSR: begin
        shift_r = {1'b0, shift_src[7:1]};
        shift_c = shift_src[0];
      end
      cpu8_exe_pkg::FUNC_ROL: begin
        shift_r = {shift_src[6:0], c_in};
        shift_c = shift_src[7];
      end
      default: begin
        shift_r = {c_in, shift_src[7:1]};
        shift_c = shift_src[0];
      end
    endcase
  end

  // Operation decode: register updates, write-back and flags.
  always_comb begin
    state_next = state;
    result     = 8'h00;
    write_back = 1'b0;
    nz_val     = 8'h00;
    nz_en      = 1'b0;
    case (op.func)
      cpu8_exe_pkg::FUNC_LDA: begin
        state_next.acc = m;
        nz_val = m;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_LDX: begin
        state_next.x = m;
        nz_val = m;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_LDY: begin
        state_next.y = m;
        nz_val = m;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_AND: begin
        state_next.acc = a & m;
        nz_val = a & m;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_ORA: begin
        state_next.acc = a | m;
        nz_val = a | m;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_EOR: begin
        state_next.acc = a ^ m;
        nz_val = a ^ m;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_BIT: begin
        state_next.flags[cpu8_exe_pkg::FLAG_Z] = ((a & m) == 8'h00);
        state_next.flags[cpu8_exe_pkg::FLAG_N] = m[7];
        state_next.flags[cpu8_exe_pkg::FLAG_V] = m[6];
      end
      cpu8_exe_pkg::FUNC_ADC: begin
        state_next.acc = adc_r;
        state_next.flags[cpu8_exe_pkg::FLAG_C] = adc_c;
        state_next.flags[cpu8_exe_pkg::FLAG_V] = ~(a[7] ^ m[7]) & (a[7] ^ adc_r[7]);
        nz_val = adc_r;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_SBC: begin
        state_next.acc = sbc_r;
        state_next.flags[cpu8_exe_pkg::FLAG_C] = sbc_c;
        state_next.flags[cpu8_exe_pkg::FLAG_V] = (a[7] ^ m[7]) & (a[7] ^ sbc_r[7]);
        nz_val = sbc_r;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_CMP, cpu8_exe_pkg::FUNC_CPX, cpu8_exe_pkg::FUNC_CPY: begin
        state_next.flags[cpu8_exe_pkg::FLAG_C] = ~cmp_diff[8];
        nz_val = cmp_diff[7:0];
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_ASL, cpu8_exe_pkg::FUNC_LSR,
      cpu8_exe_pkg::FUNC_ROL, cpu8_exe_pkg::FUNC_ROR: begin
        state_next.flags[cpu8_exe_pkg::FLAG_C] = shift_c;
        nz_val = shift_r;
        nz_en  = 1'b1;
        if (op.on_accumulator) begin
          state_next.acc = shift_r;
        end else begin
          result     = shift_r;
          write_back = 1'b1;
        end
      end
      cpu8_exe_pkg::FUNC_INC: begin
        result     = m + 8'd1;
        write_back = 1'b1;
        nz_val     = m + 8'd1;
        nz_en      = 1'b1;
      end
      cpu8_exe_pkg::FUNC_DEC: begin
        result     = m - 8'd1;
        write_back = 1'b1;
        nz_val     = m - 8'd1;
        nz_en      = 1'b1;
      end
      cpu8_exe_pkg::FUNC_INX: begin
        state_next.x = state.x + 8'd1;
        nz_val = state.x + 8'd1;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_INY: begin
        state_next.y = state.y + 8'd1;
        nz_val = state.y + 8'd1;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_DEX: begin
        state_next.x = state.x - 8'd1;
        nz_val = state.x - 8'd1;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_DEY: begin
        state_next.y = state.y - 8'd1;
        nz_val = state.y - 8'd1;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_TAX: begin
        state_next.x = state.acc;
        nz_val = state.acc;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_TAY: begin
        state_next.y = state.acc;
        nz_val = state.acc;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_TXA: begin
        state_next.acc = state.x;
        nz_val = state.x;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_TYA: begin
        state_next.acc = state.y;
        nz_val = state.y;
        nz_en  = 1'b1;
      end
      cpu8_exe_pkg::FUNC_CLC: state_next.flags[cpu8_exe_pkg::FLAG_C] = 1'b0;
      cpu8_exe_pkg::FUNC_SEC: state_next.flags[cpu8_exe_pkg::FLAG_C] = 1'b1;
      cpu8_exe_pkg::FUNC_CLD: state_next.flags[cpu8_exe_pkg::FLAG_D] = 1'b0;
      cpu8_exe_pkg::FUNC_SED: state_next.flags[cpu8_exe_pkg::FLAG_D] = 1'b1;
      cpu8_exe_pkg::FUNC_CLI: state_next.flags[cpu8_exe_pkg::FLAG_I] = 1'b0;
      cpu8_exe_pkg::FUNC_SEI: state_next.flags[cpu8_exe_pkg::FLAG_I] = 1'b1;
      cpu8_exe_pkg::FUNC_CLV: state_next.flags[cpu8_exe_pkg::FLAG_V] = 1'b0;
      cpu8_exe_pkg::FUNC_STA: begin
        result     = state.acc;
        write_back = 1'b1;
      end
      cpu8_exe_pkg::FUNC_STX: begin
        result     = state.x;
        write_back = 1'b1;
      end
      cpu8_exe_pkg::FUNC_STY: begin
        result     = state.y;
        write_back = 1'b1;
      end
      cpu8_exe_pkg::FUNC_PLP: begin
        // The pulled byte loads every flag but B, which is dropped.
        state_next.flags = m;
        state_next.flags[cpu8_exe_pkg::FLAG_B] = 1'b0;
      end
      cpu8_exe_pkg::FUNC_PHP: begin
        // The pushed copy has B set; the flags themselves stay.
        result     = state.flags;
        result[cpu8_exe_pkg::FLAG_B] = 1'b1;
        result[cpu8_exe_pkg::FLAG_U] = 1'b1;
        write_back = 1'b1;
      end
      default: begin
        // Unused codes leave everything as it is.
      end
    endcase

    if (nz_en) begin
      state_next.flags[cpu8_exe_pkg::FLAG_Z] = (nz_val == 8'h00);
      state_next.flags[cpu8_exe_pkg::FLAG_N] = nz_val[7];
    end
    // The unused status bit always reads as one.
    state_next.flags[cpu8_exe_pkg::FLAG_U] = 1'b1;
  end

endmodule

@@ hw/rtl/cpu8_register_alu_execute.sv @@
// Top level of the 8-bit CPU execute unit: input register, ALU, result register.
// Depends on cpu8_exe_pkg, cpu8_exe_alu and assert_macros.svh.
//
// Usage:
//   The op channel (op_valid, op_ready, op) carries one operation: code, operand
//   byte and the accumulator-or-memory select for shifts. The rsp channel
//   (rsp_valid, rsp_ready, rsp) returns one result per operation: write-back
//   byte and mark, packed status and the A, X and Y registers afterward.
//   Both channels move one transfer on a clock edge where valid and ready are high.
//   An operation lands in the input register on its transfer; once the result
//   register is free, it runs through the ALU into the result register and updates
//   A, X, Y and the flags, and the result is then offered on the rsp channel.
//   Throughput is one operation per cycle while results are taken: the ALU is a
//   single pass of byte-wide add, logic and shift paths; registers update on each op.
//   When the receiver stalls, the result register holds and the input register
//   keeps one more operation; op_ready drops only when both are full.
//   Synchronous reset empties both registers and sets A, X and Y to zero and the
//   status to 0x20.
module cpu8_register_alu_execute (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  output logic                 op_ready,
  input  cpu8_exe_pkg::op_t    op,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output cpu8_exe_pkg::rsp_t   rsp
);

`include "assert_macros.svh"

  logic                      stage_valid;
  cpu8_exe_pkg::op_t         stage;
  cpu8_exe_pkg::arch_state_t regs;
  cpu8_exe_pkg::arch_state_t regs_next;
  logic [7:0]                alu_result;
  logic                      alu_write_back;
  cpu8_exe_pkg::rsp_t        rsp_next;
  logic                      advance;

  // The staged operation moves on when the result register is free.
  assign advance  = stage_valid && (!rsp_valid || rsp_ready);
  assign op_ready = !stage_valid || advance;

  cpu8_exe_alu u_alu (
    .op         (stage),
    .state      (regs),
    .state_next (regs_next),
    .result     (alu_result),
    .write_back (alu_write_back)
  );

  // Assemble the outgoing result from the updated registers.
  always_comb begin
    rsp_next.result     = alu_result;
    rsp_next.write_back = alu_write_back;
    rsp_next.status     = regs_next.flags;
    rsp_next.acc_out    = regs_next.acc;
    rsp_next.x_out      = regs_next.x;
    rsp_next.y_out      = regs_next.y;
  end

  // Handshake control and the register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      rsp_valid   <= 1'b0;
      regs.acc    <= 8'h00;
      regs.x      <= 8'h00;
      regs.y      <= 8'h00;
      regs.flags  <= cpu8_exe_pkg::FLAGS_RESET;
    end else begin
      if (op_ready) begin
        stage_valid <= op_valid;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
        regs      <= regs_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (op_valid && op_ready) begin
      stage <= op;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  // The offered result always mirrors the register file it produced.
  `ASSERT_IMPLIES(a_rsp_matches_regs, rsp_valid,
    rsp.acc_out == regs.acc && rsp.x_out == regs.x && rsp.y_out == regs.y &&
    rsp.status == regs.flags)
  // A byte without write-back is always zero.
  `ASSERT_IMPLIES(a_no_wb_zero, rsp_valid && !rsp.write_back, rsp.result == 8'h00)
  // With both registers full and the receiver stalled, no new operation is taken.
  `ASSERT_IMPLIES(a_full_stall, stage_valid && rsp_valid && !rsp_ready, !op_ready)
  // The stored flags keep the unused bit set and B clear.
  `ASSERT_ALWAYS(a_flag_fixed_bits,
    regs.flags[cpu8_exe_pkg::FLAG_U] && !regs.flags[cpu8_exe_pkg::FLAG_B])

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the 8-bit CPU execute unit cpu8_register_alu_execute.
// Depends on cpu8_exe_pkg for the payload types, operation codes and flag positions.
// Operations are predicted in the bench, and every result transfer is compared field by field.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cpu8_exe_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_SHOWN = 10;
  localparam int PHASE_OPS = 260;
  localparam int HOLD_AT = 650;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic op_valid = 1'b0;
  logic op_ready;
  op_t  op = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  cpu8_register_alu_execute DUT (
    .clk(clk),
    .rst(rst),
    .op_valid(op_valid),
    .op_ready(op_ready),
    .op(op),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #5ns clk = ~clk;

  // Operations waiting to be offered, and results waiting to come back.
  op_t  pending_ops[$];
  rsp_t expected_rsps[$];

  // Predicted register file of the unit.
  logic [7:0] pred_acc = 8'h00;
  logic [7:0] pred_x = 8'h00;
  logic [7:0] pred_y = 8'h00;
  logic [7:0] pred_flags = FLAGS_RESET;

  int tx_idle_pct = 16;
  int rx_idle_pct = 88;
  int total_ops = 0;
  int unused_ops = 0;
  int ops_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit op_taken = 1'b0;

  // Flag update; the unused bit always reads one.
  function automatic void put_flag(int pos, logic on);
    pred_flags[pos[2:0]] = on;
    pred_flags[FLAG_U] = 1'b1;
  endfunction

  function automatic void put_nz(logic [7:0] v);
    put_flag(FLAG_Z, v == 8'h00);
    put_flag(FLAG_N, v[7]);
  endfunction

  // Add with carry, binary or decimal.
  function automatic void add_to_acc(logic [7:0] m);
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] r;
    logic [7:0]  a;
    a = pred_acc;
    if (pred_flags[FLAG_D]) begin
      lo = {12'h000, a[3:0]} + {12'h000, m[3:0]} + {15'h0000, pred_flags[FLAG_C]};
      hi = {8'h00, a[7:4], 4'h0} + {8'h00, m[7:4], 4'h0};
      if (lo > 16'h0009) begin
        hi += 16'h0010;
        lo += 16'h0006;
      end
      if (hi > 16'h0090) hi += 16'h0060;
      put_flag(FLAG_C, hi[15:8] != 8'h00);
      r = {8'h00, hi[7:4], lo[3:0]};
    end else begin
      r = {8'h00, a} + {8'h00, m} + {15'h0000, pred_flags[FLAG_C]};
      put_flag(FLAG_C, r > 16'h00FF);
    end
    put_flag(FLAG_V, ((~(a ^ m)) & (a ^ r[7:0]) & 8'h80) != 8'h00);
    pred_acc = r[7:0];
    put_nz(pred_acc);
  endfunction

  // Subtract with borrow, binary or decimal.
  function automatic void sub_from_acc(logic [7:0] m);
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] r;
    logic [7:0]  a;
    logic        nb;
    a = pred_acc;
    nb = ~pred_flags[FLAG_C];
    if (pred_flags[FLAG_D]) begin
      lo = {12'h000, a[3:0]} - {12'h000, m[3:0]} - {15'h0000, nb};
      hi = {8'h00, a[7:4], 4'h0} - {8'h00, m[7:4], 4'h0};
      if (lo[4]) begin
        hi -= 16'h0010;
        lo -= 16'h0006;
      end
      if (hi[8]) hi -= 16'h0060;
      r = {8'h00, hi[7:4], lo[3:0]};
      put_flag(FLAG_C, hi[15:8] == 8'h00);
    end else begin
      r = {8'h00, a} - {8'h00, m} - {15'h0000, nb};
      put_flag(FLAG_C, r < 16'h0100);
    end
    put_flag(FLAG_V, ((a ^ m) & (a ^ r[7:0]) & 8'h80) != 8'h00);
    pred_acc = r[7:0];
    put_nz(pred_acc);
  endfunction

  function automatic void compare_with(logic [7:0] reg_v, logic [7:0] m);
    logic [7:0] d;
    d = reg_v - m;
    put_flag(FLAG_N, d[7]);
    put_flag(FLAG_Z, d == 8'h00);
    put_flag(FLAG_C, reg_v >= m);
  endfunction

  // Shifts and rotates through the carry.
  function automatic logic [7:0] shift_byte(logic [5:0] func, logic [7:0] v);
    logic       cin;
    logic       cout;
    logic [7:0] r;
    cin = pred_flags[FLAG_C];
    case (func)
      FUNC_ASL: begin
        cout = v[7];
        r = {v[6:0], 1'b0};
      end
      FUNC_LSR: begin
        cout = v[0];
        r = {1'b0, v[7:1]};
      end
      FUNC_ROL: begin
        cout = v[7];
        r = {v[6:0], cin};
      end
      default: begin
        cout = v[0];
        r = {cin, v[7:1]};
      end
    endcase
    put_flag(FLAG_C, cout);
    put_nz(r);
    return r;
  endfunction

  // Runs one operation on the predicted registers and forms its result.
  function automatic rsp_t execute_op(op_t o);
    rsp_t       e;
    logic [7:0] res;
    logic       wb;
    res = 8'h00;
    wb = 1'b0;
    case (o.func)
      FUNC_LDA: begin
        pred_acc = o.operand;
        put_nz(pred_acc);
      end
      FUNC_LDX: begin
        pred_x = o.operand;
        put_nz(pred_x);
      end
      FUNC_LDY: begin
        pred_y = o.operand;
        put_nz(pred_y);
      end
      FUNC_AND: begin
        pred_acc &= o.operand;
        put_nz(pred_acc);
      end
      FUNC_ORA: begin
        pred_acc |= o.operand;
        put_nz(pred_acc);
      end
      FUNC_EOR: begin
        pred_acc ^= o.operand;
        put_nz(pred_acc);
      end
      FUNC_BIT: begin
        put_flag(FLAG_Z, (pred_acc & o.operand) == 8'h00);
        put_flag(FLAG_N, o.operand[7]);
        put_flag(FLAG_V, o.operand[6]);
      end
      FUNC_ADC: add_to_acc(o.operand);
      FUNC_SBC: sub_from_acc(o.operand);
      FUNC_CMP: compare_with(pred_acc, o.operand);
      FUNC_CPX: compare_with(pred_x, o.operand);
      FUNC_CPY: compare_with(pred_y, o.operand);
      FUNC_ASL, FUNC_LSR, FUNC_ROL, FUNC_ROR: begin
        if (o.on_accumulator) begin
          pred_acc = shift_byte(o.func, pred_acc);
        end else begin
          res = shift_byte(o.func, o.operand);
          wb = 1'b1;
        end
      end
      FUNC_INC: begin
        res = o.operand + 8'd1;
        wb = 1'b1;
        put_nz(res);
      end
      FUNC_DEC: begin
        res = o.operand - 8'd1;
        wb = 1'b1;
        put_nz(res);
      end
      FUNC_INX: begin
        pred_x = pred_x + 8'd1;
        put_nz(pred_x);
      end
      FUNC_INY: begin
        pred_y = pred_y + 8'd1;
        put_nz(pred_y);
      end
      FUNC_DEX: begin
        pred_x = pred_x - 8'd1;
        put_nz(pred_x);
      end
      FUNC_DEY: begin
        pred_y = pred_y - 8'd1;
        put_nz(pred_y);
      end
      FUNC_TAX: begin
        pred_x = pred_acc;
        put_nz(pred_x);
      end
      FUNC_TAY: begin
        pred_y = pred_acc;
        put_nz(pred_y);
      end
      FUNC_TXA: begin
        pred_acc = pred_x;
        put_nz(pred_acc);
      end
      FUNC_TYA: begin
        pred_acc = pred_y;
        put_nz(pred_acc);
      end
      FUNC_CLC: put_flag(FLAG_C, 1'b0);
      FUNC_SEC: put_flag(FLAG_C, 1'b1);
      FUNC_CLD: put_flag(FLAG_D, 1'b0);
      FUNC_SED: put_flag(FLAG_D, 1'b1);
      FUNC_CLI: put_flag(FLAG_I, 1'b0);
      FUNC_SEI: put_flag(FLAG_I, 1'b1);
      FUNC_CLV: put_flag(FLAG_V, 1'b0);
      FUNC_STA: begin
        res = pred_acc;
        wb = 1'b1;
      end
      FUNC_STX: begin
        res = pred_x;
        wb = 1'b1;
      end
      FUNC_STY: begin
        res = pred_y;
        wb = 1'b1;
      end
      FUNC_PLP: begin
        // The pulled byte loses B and gets the unused bit.
        pred_flags = o.operand;
        pred_flags[FLAG_B] = 1'b0;
        pred_flags[FLAG_U] = 1'b1;
      end
      FUNC_PHP: begin
        // The pushed copy has B forced on; the flags stay as they are.
        res = pred_flags;
        res[FLAG_B] = 1'b1;
        res[FLAG_U] = 1'b1;
        wb = 1'b1;
      end
      default: ;
    endcase
    e.result = wb ? res : 8'h00;
    e.write_back = wb;
    e.status = pred_flags;
    e.status[FLAG_U] = 1'b1;
    e.acc_out = pred_acc;
    e.x_out = pred_x;
    e.y_out = pred_y;
    return e;
  endfunction

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("mismatch in %s of result %0d: expected %02h, got %02h",
                 field, results_seen, want, got);
    end
  endtask

  // Monitor: checks result transfers and predicts each operation transfer.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        results_seen++;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result %0d arrived with nothing expected: %h", results_seen, rsp);
        end else begin
          want = expected_rsps.pop_front();
          check_field("result", want.result, rsp.result);
          check_field("write_back", {7'b0, want.write_back}, {7'b0, rsp.write_back});
          check_field("status", want.status, rsp.status);
          check_field("acc_out", want.acc_out, rsp.acc_out);
          check_field("x_out", want.x_out, rsp.x_out);
          check_field("y_out", want.y_out, rsp.y_out);
        end
      end
      if (op_valid && op_ready) begin
        expected_rsps.push_back(execute_op(op));
        ops_sent++;
        op_taken = 1'b1;
      end
    end
  end

  // Driver: offers the next pending operation once the current one is transferred.
  always @(negedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (!op_valid || op_taken) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        op <= pending_ops.pop_front();
        op_valid <= 1'b1;
      end else begin
        op_valid <= 1'b0;
      end
    end
    op_taken = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off that backs up the unit.
  always @(negedge clk) begin
    if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic push_op(logic [5:0] func, logic [7:0] operand, logic on_acc);
    op_t o;
    o.func = func;
    o.operand = operand;
    o.on_accumulator = on_acc;
    pending_ops.push_back(o);
    total_ops++;
    if (func > FUNC_PHP) unused_ops++;
  endtask

  function automatic logic [7:0] pick_operand();
    logic [7:0] corners[8] = '{8'h00, 8'h01, 8'h09, 8'h50, 8'h7F, 8'h80, 8'h99, 8'hFF};
    if ($urandom_range(99) < 25) return corners[3'($urandom_range(7))];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_bcd();
    return {4'($urandom_range(9)), 4'($urandom_range(9))};
  endfunction

  // Mostly random operations, with decimal arithmetic runs and a few unused codes.
  task automatic push_random_ops(int count);
    int kind;
    int n;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if (kind < 20) begin
        push_op(FUNC_SED, pick_operand(), 1'($urandom_range(1)));
        push_op($urandom_range(1) ? FUNC_SEC : FUNC_CLC, pick_operand(), 1'($urandom_range(1)));
        push_op(FUNC_LDA, pick_bcd(), 1'($urandom_range(1)));
        n = $urandom_range(3, 1);
        for (int j = 0; j < n; j++)
          push_op($urandom_range(1) ? FUNC_ADC : FUNC_SBC,
                  $urandom_range(3) == 0 ? pick_operand() : pick_bcd(), 1'($urandom_range(1)));
        if ($urandom_range(1)) push_op(FUNC_CLD, pick_operand(), 1'($urandom_range(1)));
        i += 3 + n;
      end else if (kind < 25) begin
        push_op(6'($urandom_range(63, FUNC_PHP + 1)), pick_operand(), 1'($urandom_range(1)));
      end else if (kind < 45) begin
        push_op($urandom_range(1) ? FUNC_ADC : FUNC_SBC, pick_operand(), 1'($urandom_range(1)));
      end else begin
        push_op(6'($urandom_range(FUNC_PHP)), pick_operand(), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic wait_all_sent();
    while (ops_sent != total_ops) @(negedge clk);
  endtask

  // Stimulus: directed operations, then three idle patterns of random traffic.
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_op(FUNC_LDA, 8'h00, 1'b0);
    push_op(FUNC_LDA, 8'h80, 1'b1);
    push_op(FUNC_LDX, 8'hFF, 1'b0);
    push_op(FUNC_LDY, 8'h01, 1'b1);
    push_op(FUNC_LDA, 8'hFF, 1'b0);
    push_op(FUNC_AND, 8'h0F, 1'b0);
    push_op(FUNC_ORA, 8'hF0, 1'b0);
    push_op(FUNC_EOR, 8'hFF, 1'b0);
    push_op(FUNC_BIT, 8'hC0, 1'b0);
    push_op(FUNC_CLC, 8'h00, 1'b0);
    push_op(FUNC_LDA, 8'h7F, 1'b0);
    push_op(FUNC_ADC, 8'h01, 1'b0);
    push_op(FUNC_SEC, 8'h00, 1'b0);
    push_op(FUNC_SBC, 8'hFF, 1'b0);
    // Decimal carry out of 99 and borrow below 00.
    push_op(FUNC_SED, 8'h00, 1'b0);
    push_op(FUNC_LDA, 8'h99, 1'b0);
    push_op(FUNC_ADC, 8'h01, 1'b0);
    push_op(FUNC_SBC, 8'h01, 1'b0);
    push_op(FUNC_CLD, 8'h00, 1'b0);
    push_op(FUNC_CMP, 8'h99, 1'b0);
    push_op(FUNC_CPX, 8'hFF, 1'b0);
    push_op(FUNC_CPY, 8'h02, 1'b0);
    // Shifts on the accumulator and on memory.
    push_op(FUNC_ASL, 8'hFF, 1'b1);
    push_op(FUNC_LSR, 8'h01, 1'b0);
    push_op(FUNC_ROL, 8'h00, 1'b1);
    push_op(FUNC_ROR, 8'h80, 1'b0);
    push_op(FUNC_INC, 8'hFF, 1'b0);
    push_op(FUNC_DEC, 8'h00, 1'b1);
    push_op(FUNC_INX, 8'h00, 1'b0);
    push_op(FUNC_INY, 8'h00, 1'b0);
    push_op(FUNC_DEX, 8'h00, 1'b0);
    push_op(FUNC_DEY, 8'h00, 1'b0);
    push_op(FUNC_TAX, 8'h00, 1'b0);
    push_op(FUNC_TAY, 8'h00, 1'b0);
    push_op(FUNC_TXA, 8'h00, 1'b0);
    push_op(FUNC_TYA, 8'h00, 1'b0);
    push_op(FUNC_SEI, 8'h00, 1'b0);
    push_op(FUNC_CLI, 8'h00, 1'b0);
    push_op(FUNC_CLV, 8'h00, 1'b0);
    push_op(FUNC_STA, 8'hFF, 1'b0);
    push_op(FUNC_STX, 8'h00, 1'b1);
    push_op(FUNC_STY, 8'hFF, 1'b0);
    // Status pull and push, with B and the unused bit forced.
    push_op(FUNC_PLP, 8'hFF, 1'b0);
    push_op(FUNC_PHP, 8'h00, 1'b0);
    push_op(FUNC_PLP, 8'h00, 1'b0);
    push_op(FUNC_PHP, 8'h00, 1'b0);
    push_op(6'd38, 8'hFF, 1'b1);
    push_op(6'd63, 8'h00, 1'b0);
    push_random_ops(PHASE_OPS);
    wait_all_sent();

    tx_idle_pct = 88;
    rx_idle_pct = 16;
    push_random_ops(PHASE_OPS);
    wait_all_sent();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    push_random_ops(PHASE_OPS);
    wait_all_sent();

    while (expected_rsps.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d operations (%0d with unused codes) under three idle patterns",
             total_ops, unused_ops);
    $display("and one %0d-cycle output stall; %0d results checked, %0d mismatches.",
             HOLD_CYCLES, results_seen, mismatches);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still expected",
             CYCLE_LIMIT, expected_rsps.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ cpu8_register_alu_execute.f @@
+incdir+hw/rtl
hw/rtl/cpu8_exe_pkg.sv
hw/rtl/cpu8_exe_alu.sv
hw/rtl/cpu8_register_alu_execute.sv
sim/testbench.sv
